FILE: rtl/bsh_pkg.sv
// Shared types, constants and helper functions for the byte stream hash core.
// Used by the multiplier, datapath, controller and top level; no dependencies.
`default_nettype none

package bsh_pkg;

   localparam int unsigned COUNT_BITS_DEFAULT = 32;
   localparam int unsigned NUM_WORDS          = 4;
   localparam int unsigned IDX_BITS           = 2;
   localparam logic [IDX_BITS-1:0] IDX_LAST   = IDX_BITS'(NUM_WORDS - 1);
   localparam logic [31:0] KEY_LENGTH_MAX     = 32'hFFFF_FFFF;

   localparam logic [63:0] INIT_WORDS [NUM_WORDS] = '{
      64'h243f_6a88_85a3_08d3, 64'h1319_8a2e_0370_7344,
      64'ha409_3822_299f_31d0, 64'h082e_fa98_ec4e_6c89
   };

   localparam logic [63:0] WORD_MUL [NUM_WORDS] = '{
      64'h9e37_79b1_85eb_ca87, 64'hc2b2_ae3d_27d4_eb4f,
      64'h1656_67b1_9e37_79f9, 64'hd6e8_feb8_6659_fd93
   };

   // Golden-ratio constant times (word index + 1), modulo 2^64
   localparam logic [63:0] GOLD_MULT [NUM_WORDS] = '{
      64'h9e37_79b9_7f4a_7c15, 64'h3c6e_f372_fe94_f82a,
      64'hdaa6_6d2c_7ddf_743f, 64'h78dd_e6e5_fd29_f054
   };

   localparam logic [63:0] FIN_MUL1 = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] FIN_MUL2 = 64'h94d0_49bb_1331_11eb;

   typedef enum logic [1:0] {
      OP_ABSORB        = 2'd0,
      OP_ABSORB_FINISH = 2'd1,
      OP_FINISH        = 2'd2,
      OP_NONE          = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MUL_HOLD,
      MUL_LO,
      MUL_X1,
      MUL_X2
   } mul_step_type;

   typedef enum logic [1:0] {
      MSEL_WORD,
      MSEL_WORD_REV,
      MSEL_FIN1,
      MSEL_FIN2
   } mul_sel_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_ABS_LOAD,
      DP_ABS_STORE,
      DP_FIN_LOAD,
      DP_FIN_MIX30,
      DP_FIN_MIX27,
      DP_FIN_STORE,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      mul_step_type        mul;
      mul_sel_type         msel;
      logic [IDX_BITS-1:0] idx;
   } dp_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ABS_LOAD,
      ST_MUL_LO,
      ST_MUL_X1,
      ST_MUL_X2,
      ST_ABS_STORE,
      ST_FIN_LOAD,
      ST_FIN_MIX30,
      ST_FIN_MIX27,
      ST_FIN_STORE,
      ST_PUBLISH
   } ctrl_state_type;

   // Rotate left by the word's fixed amount, then xor-shift right by 31
   function automatic logic [63:0] rotate_mix(input logic [63:0] w,
                                              input logic [IDX_BITS-1:0] idx);
      logic [63:0] r;
      case (idx)
         2'd0:    r = {w[46:0], w[63:47]};
         2'd1:    r = {w[34:0], w[63:35]};
         2'd2:    r = {w[22:0], w[63:23]};
         default: r = {w[10:0], w[63:11]};
      endcase
      return r ^ (r >> 31);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bsh_mul.sv
// Iterative 64x64 multiplier keeping the low 64 bits of the product.
// One 32x32 multiplier, three steps per product; depends on bsh_pkg.
`default_nettype none

module bsh_mul (
   input  logic                 clock,
   input  bsh_pkg::mul_step_type step,
   input  logic [63:0]          a,
   input  logic [63:0]          b,
   output logic [63:0]          prod
);
   import bsh_pkg::*;

   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [63:0] pp;
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   // low x low, then the two cross terms shifted up; high x high drops out
   always_comb begin
      case (step)
         MUL_X1: begin
            op_a = a[31:0];
            op_b = b[63:32];
         end
         MUL_X2: begin
            op_a = a[63:32];
            op_b = b[31:0];
         end
         default: begin
            op_a = a[31:0];
            op_b = b[31:0];
         end
      endcase
   end

   assign pp = op_a * op_b;

   always_comb begin
      case (step)
         MUL_LO:         prod_in = pp;
         MUL_X1, MUL_X2: prod_in = prod_ff + {pp[31:0], 32'b0};
         default:        prod_in = prod_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: rtl/bsh_dp.sv
// Datapath: running words, byte count, working register, multiplier and result registers.
// Driven by commands from bsh_ctrl; depends on bsh_pkg and bsh_mul.
`default_nettype none

module bsh_dp #(
   parameter int unsigned COUNT_BITS = bsh_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  bsh_pkg::dp_cmd_type cmd,
   input  logic [7:0]          data_byte,
   output logic [63:0]         digest_word_a,
   output logic [63:0]         digest_word_b,
   output logic [63:0]         digest_word_c,
   output logic [63:0]         digest_word_d,
   output logic [31:0]         key_length
);
   import bsh_pkg::*;

   logic [63:0]           words_ff [NUM_WORDS];
   logic [63:0]           words_in [NUM_WORDS];
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [7:0]            byte_ff;
   logic [63:0]           acc_ff;
   logic [63:0]           acc_in;
   logic [63:0]           digest_ff [NUM_WORDS];
   logic [31:0]           key_length_ff;

   logic [63:0] count64;
   logic [63:0] word_sel;
   logic [63:0] absorb_term;
   logic [63:0] fin_mix;
   logic [63:0] mul_b;
   logic [63:0] prod;

   assign count64     = 64'(count_ff);
   assign word_sel    = words_ff[cmd.idx];
   assign absorb_term = 64'(byte_ff) + (count64 << (3'(cmd.idx) + 3'd1)) + GOLD_MULT[cmd.idx];
   assign fin_mix     = word_sel ^ prod;

   always_comb begin
      case (cmd.msel)
         MSEL_WORD:     mul_b = WORD_MUL[cmd.idx];
         MSEL_WORD_REV: mul_b = WORD_MUL[~cmd.idx];
         MSEL_FIN1:     mul_b = FIN_MUL1;
         default:       mul_b = FIN_MUL2;
      endcase
   end

   bsh_mul u_mul (
      .clock (clock),
      .step  (cmd.mul),
      .a     (acc_ff),
      .b     (mul_b),
      .prod  (prod)
   );

   always_comb begin
      case (cmd.op)
         DP_ABS_LOAD:  acc_in = word_sel ^ absorb_term;
         DP_FIN_LOAD:  acc_in = count64;
         DP_FIN_MIX30: acc_in = fin_mix ^ (fin_mix >> 30);
         DP_FIN_MIX27: acc_in = prod ^ (prod >> 27);
         default:      acc_in = acc_ff;
      endcase
   end

   always_comb begin
      words_in = words_ff;
      count_in = count_ff;
      case (cmd.op)
         DP_ABS_STORE: begin
            words_in[cmd.idx] = rotate_mix(prod, cmd.idx);
            if (cmd.idx == IDX_LAST && count_ff != {COUNT_BITS{1'b1}}) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         DP_FIN_STORE: begin
            words_in[cmd.idx] = prod ^ (prod >> 31);
         end
         DP_PUBLISH: begin
            words_in = INIT_WORDS;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= INIT_WORDS;
         count_ff <= '0;
      end else begin
         words_ff <= words_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.op == DP_CAPTURE) begin
         byte_ff <= data_byte;
      end
      if (cmd.op == DP_PUBLISH) begin
         digest_ff     <= words_ff;
         key_length_ff <= (count64 > 64'(KEY_LENGTH_MAX)) ? KEY_LENGTH_MAX : count64[31:0];
      end
   end

   assign digest_word_a = digest_ff[0];
   assign digest_word_b = digest_ff[1];
   assign digest_word_c = digest_ff[2];
   assign digest_word_d = digest_ff[3];
   assign key_length    = key_length_ff;

endmodule

`default_nettype wire

FILE: rtl/bsh_ctrl.sv
// Controller state machine: handshakes, word sequencing and multiplier steps.
// Issues dp_cmd_type commands to bsh_dp; depends on bsh_pkg.
`default_nettype none

module bsh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bsh_pkg::dp_cmd_type cmd
);
   import bsh_pkg::*;

   ctrl_state_type      state_ff, state_in;
   ctrl_state_type      ret_ff, ret_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   mul_sel_type         msel_ff, msel_in;
   op_type              op_ff, op_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;
   logic                publish_fire;

   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign publish_fire = (state_ff == ST_PUBLISH) && slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      idx_in   = idx_ff;
      msel_in  = msel_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = op_type'(req_op);
               idx_in = '0;
               case (op_type'(req_op))
                  OP_ABSORB, OP_ABSORB_FINISH: state_in = ST_ABS_LOAD;
                  OP_FINISH:                   state_in = ST_FIN_LOAD;
                  default:                     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ABS_LOAD: begin
            state_in = ST_MUL_LO;
            ret_in   = ST_ABS_STORE;
            msel_in  = MSEL_WORD;
         end
         ST_MUL_LO: state_in = ST_MUL_X1;
         ST_MUL_X1: state_in = ST_MUL_X2;
         ST_MUL_X2: state_in = ret_ff;
         ST_ABS_STORE: begin
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = (op_ff == OP_ABSORB_FINISH) ? ST_FIN_LOAD : ST_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_BITS'(1);
               state_in = ST_ABS_LOAD;
            end
         end
         ST_FIN_LOAD: begin
            state_in = ST_MUL_LO;
            ret_in   = ST_FIN_MIX30;
            msel_in  = MSEL_WORD_REV;
         end
         ST_FIN_MIX30: begin
            state_in = ST_MUL_LO;
            ret_in   = ST_FIN_MIX27;
            msel_in  = MSEL_FIN1;
         end
         ST_FIN_MIX27: begin
            state_in = ST_MUL_LO;
            ret_in   = ST_FIN_STORE;
            msel_in  = MSEL_FIN2;
         end
         ST_FIN_STORE: begin
            if (idx_ff == IDX_LAST) begin
               state_in = ST_PUBLISH;
            end else begin
               idx_in   = idx_ff + IDX_BITS'(1);
               state_in = ST_FIN_LOAD;
            end
         end
         ST_PUBLISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (publish_fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      cmd.op    = DP_NOP;
      cmd.mul   = MUL_HOLD;
      cmd.msel  = msel_ff;
      cmd.idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.op    = req_valid ? DP_CAPTURE : DP_NOP;
         end
         ST_ABS_LOAD:  cmd.op  = DP_ABS_LOAD;
         ST_MUL_LO:    cmd.mul = MUL_LO;
         ST_MUL_X1:    cmd.mul = MUL_X1;
         ST_MUL_X2:    cmd.mul = MUL_X2;
         ST_ABS_STORE: cmd.op  = DP_ABS_STORE;
         ST_FIN_LOAD:  cmd.op  = DP_FIN_LOAD;
         ST_FIN_MIX30: cmd.op  = DP_FIN_MIX30;
         ST_FIN_MIX27: cmd.op  = DP_FIN_MIX27;
         ST_FIN_STORE: cmd.op  = DP_FIN_STORE;
         ST_PUBLISH:   cmd.op  = slot_free ? DP_PUBLISH : DP_NOP;
         default:      cmd.op  = DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         idx_ff       <= '0;
         msel_ff      <= MSEL_WORD;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         idx_ff       <= idx_in;
         msel_ff      <= msel_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/byte_stream_hash_256_core.sv
// Top level of the byte stream hash core: controller plus datapath.
// Depends on bsh_pkg, bsh_ctrl, bsh_dp (and bsh_mul below it).
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid / req_stall | req_op, req_data_byte
//  rsp     | out       | rsp_valid / rsp_stall | rsp_digest_word_a..d, rsp_key_length
//
// An absorb byte is accepted, then each word in turn is loaded, put through three
// multiplier steps and stored, using the single 32x32 multiplier shared by all four words.
// A finish then forms three 64-bit products for each word and stores it, then publishes;
// op 3 is accepted and dropped.
// Synchronous active-high reset returns the running words to their initial constants,
// clears the byte count and drops rsp_valid; the result registers are not reset.
// rsp_stall holds the finished result in its output register while the next key streams
// in; only the publish of the following digest waits for that transfer.

module byte_stream_hash_256_core #(
   parameter int unsigned COUNT_BITS = bsh_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word_a,
   output logic [63:0] rsp_digest_word_b,
   output logic [63:0] rsp_digest_word_c,
   output logic [63:0] rsp_digest_word_d,
   output logic [31:0] rsp_key_length
);
   import bsh_pkg::*;

   dp_cmd_type cmd;

   // Sequence words and multiplier steps; own both handshakes
   bsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Hold the hash state and the result registers
   bsh_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .data_byte     (req_data_byte),
      .digest_word_a (rsp_digest_word_a),
      .digest_word_b (rsp_digest_word_b),
      .digest_word_c (rsp_digest_word_c),
      .digest_word_d (rsp_digest_word_d),
      .key_length    (rsp_key_length)
   );

   // A publish never overwrites a result that is still waiting for its transfer
   a_publish_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_PUBLISH) |-> (!rsp_valid || !rsp_stall))
      else $error("publish while result pending");

   // A publish always presents a result in the next cycle
   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_PUBLISH) |=> rsp_valid)
      else $error("publish without rsp_valid");

   // Any accepted working op keeps the input stalled in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op != OP_NONE) |=> req_stall)
      else $error("input not stalled after accepted op");

endmodule

`default_nettype wire

FILE: sim/byte_stream_hash_256_core_tb.sv
// Self-checking testbench for byte_stream_hash_256_core: a directed table, then random keys.
// A built-in predictor of the 256-bit byte stream hash checks every digest.
// Depends on bsh_pkg and the RTL under rtl/.
`default_nettype none

module byte_stream_hash_256_core_tb;
   import bsh_pkg::*;

   localparam int unsigned CNT_W = COUNT_BITS_DEFAULT;
   // Highest value the byte counter holds before it saturates
   localparam logic [63:0] COUNT_CAP = (CNT_W >= 64) ? '1 : ((64'd1 << CNT_W) - 64'd1);
   localparam int RANDOM_ITEMS = 650;
   localparam int TAIL_CYCLES  = 80;

   // Hash constants, written out here so the predictor stays independent of the RTL
   localparam logic [63:0] SEED_WORD [4] = '{
      64'h243f6a8885a308d3, 64'h13198a2e03707344,
      64'ha4093822299f31d0, 64'h082efa98ec4e6c89
   };
   localparam logic [63:0] LANE_MUL [4] = '{
      64'h9e3779b185ebca87, 64'hc2b2ae3d27d4eb4f,
      64'h165667b19e3779f9, 64'hd6e8feb86659fd93
   };
   localparam int          LANE_ROT [4] = '{17, 29, 41, 53};
   localparam logic [63:0] GOLDEN       = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

   typedef struct packed {
      logic [3:0][63:0] words;    // words[0] goes to rsp_digest_word_a
      logic [31:0]      length;
   } digest_type;

   // One row of the directed table; typed_len < 0 leaves the length to the predictor
   typedef struct {
      op_type      op;
      logic [7:0]  data;
      int          typed_len;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 19;
   stim_row_type directed_table [DIRECTED_ROWS] = '{
      '{OP_FINISH,        8'h00,  0},   // empty key straight after reset
      '{OP_NONE,          8'hFF, -1},   // unused op, dropped
      '{OP_FINISH,        8'hA5,  0},   // byte ignored on a bare finish
      '{OP_ABSORB_FINISH, 8'h00,  1},
      '{OP_ABSORB_FINISH, 8'hFF,  1},
      '{OP_ABSORB,        8'h00, -1},
      '{OP_ABSORB,        8'hFF, -1},
      '{OP_NONE,          8'h5A, -1},   // unused op in the middle of a key
      '{OP_ABSORB,        8'h80, -1},
      '{OP_ABSORB,        8'h01, -1},
      '{OP_ABSORB_FINISH, 8'h7F,  5},
      '{OP_ABSORB,        8'hAA, -1},
      '{OP_ABSORB,        8'h55, -1},
      '{OP_FINISH,        8'hFF,  2},
      '{OP_NONE,          8'h00, -1},
      '{OP_ABSORB,        8'hFF, -1},
      '{OP_NONE,          8'hFF, -1},
      '{OP_FINISH,        8'h00,  1},
      '{OP_ABSORB_FINISH, 8'h3C,  1}
   };

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op        = OP_NONE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [63:0] rsp_digest_word_a;
   logic [63:0] rsp_digest_word_b;
   logic [63:0] rsp_digest_word_c;
   logic [63:0] rsp_digest_word_d;
   logic [31:0] rsp_key_length;

   // Predictor state: running words and saturating byte count of the open key
   logic [63:0] hash_words [4];
   logic [63:0] hash_count;
   digest_type  pending_digests [$];

   int fail_count = 0;
   int hold_left  = 0;    // cycles the receiver still stalls the waiting digest
   bit quiet      = 1'b0; // when set, neither side idles

   byte_stream_hash_256_core #(
      .COUNT_BITS(CNT_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word_a(rsp_digest_word_a),
      .rsp_digest_word_b(rsp_digest_word_b),
      .rsp_digest_word_c(rsp_digest_word_c),
      .rsp_digest_word_d(rsp_digest_word_d),
      .rsp_key_length   (rsp_key_length)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // Return to the start of a key: seed words, zero count
   function automatic void clear_hash();
      for (int i = 0; i < 4; i++)
         hash_words[i] = SEED_WORD[i];
      hash_count = 64'd0;
   endfunction

   // Fold one key byte into all four words, then advance the count (saturating)
   function automatic void absorb_key_byte(input logic [7:0] b);
      logic [63:0] w;
      logic [63:0] k;
      for (int i = 0; i < 4; i++) begin
         k = 64'(i + 1);
         w = hash_words[i];
         w = w ^ (64'(b) + (hash_count << (i + 1)) + GOLDEN * k);
         w = w * LANE_MUL[i];
         w = (w << LANE_ROT[i]) | (w >> (64 - LANE_ROT[i]));
         w = w ^ (w >> 31);
         hash_words[i] = w;
      end
      if (hash_count < COUNT_CAP)
         hash_count = hash_count + 64'd1;
   endfunction

   // Mix in the length with the lane multipliers reversed, then run the finalizer
   function automatic digest_type finish_digest();
      digest_type d;
      logic [63:0] w;
      for (int i = 0; i < 4; i++) begin
         w = hash_words[i] ^ (hash_count * LANE_MUL[3 - i]);
         w = w ^ (w >> 30);
         w = w * MIX_MUL_A;
         w = w ^ (w >> 27);
         w = w * MIX_MUL_B;
         w = w ^ (w >> 31);
         d.words[i] = w;
      end
      d.length = (hash_count > 64'hFFFF_FFFF) ? KEY_LENGTH_MAX : hash_count[31:0];
      return d;
   endfunction

   // ---------------------------------------------------------------------------------
   // Reporting
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // ---------------------------------------------------------------------------------
   // Request side: one transfer per call, after a random number of idle cycles
   // ---------------------------------------------------------------------------------

   task automatic send_item(input op_type op, input logic [7:0] b, input int typed_len);
      int gap;
      digest_type d;
      gap = quiet ? 0 : $urandom_range(0, 8);
      // Idle with junk on the payload; valid stays low
      repeat (gap) begin
         @(negedge clock);
         req_valid     <= 1'b0;
         req_op        <= 2'($urandom_range(0, 3));
         req_data_byte <= 8'($urandom_range(0, 255));
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= b;
      // Hold the payload until the block takes the transfer
      do @(posedge clock); while (req_stall);

      case (op)
         OP_ABSORB: absorb_key_byte(b);
         OP_ABSORB_FINISH, OP_FINISH: begin
            if (op == OP_ABSORB_FINISH)
               absorb_key_byte(b);
            d = finish_digest();
            if (typed_len >= 0)
               d.length = 32'(typed_len);
            pending_digests = {pending_digests, d};
            clear_hash();
         end
         default: ;   // unused op: drop, state unchanged
      endcase
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: draw a stall length per digest, count it down while the digest waits
   // ---------------------------------------------------------------------------------

   always @(negedge clock)
      rsp_stall <= (hold_left != 0);

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_digests.size() == 0) begin
            report_mismatch($sformatf("digest with none pending, word a %h",
                                      rsp_digest_word_a));
         end else begin
            want = pending_digests.pop_front();
            check_field("digest_word_a", rsp_digest_word_a, want.words[0]);
            check_field("digest_word_b", rsp_digest_word_b, want.words[1]);
            check_field("digest_word_c", rsp_digest_word_c, want.words[2]);
            check_field("digest_word_d", rsp_digest_word_d, want.words[3]);
            check_field("key_length", 64'(rsp_key_length), 64'(want.length));
         end
         hold_left = quiet ? 0 : $urandom_range(0, 8);
      end else if (rsp_valid && hold_left > 0) begin
         hold_left = hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------

   initial begin
      int sent;
      int key_len;
      bit merge_finish;
      bit last_byte;
      clear_hash();

      // Hold reset, then release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: extremes, every op, empty keys, unused op inside a key
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_item(directed_table[r].op, directed_table[r].data,
                   directed_table[r].typed_len);

      // Random keys: mostly short, a few long, with stray unused ops mixed in.
      // Some keys run with no idling on either side.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
         merge_finish = (key_len > 0) && ($urandom_range(0, 1) == 1);
         for (int j = 0; j < key_len; j++) begin
            if ($urandom_range(0, 11) == 0)
               send_item(OP_NONE, 8'($urandom_range(0, 255)), -1);
            last_byte = merge_finish && (j == key_len - 1);
            send_item(last_byte ? OP_ABSORB_FINISH : OP_ABSORB,
                      8'($urandom_range(0, 255)), -1);
            sent++;
         end
         if (!merge_finish) begin
            send_item(OP_FINISH, 8'($urandom_range(0, 255)), -1);
            sent++;
         end
      end
      quiet = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain every pending digest, then watch a little longer for strays
      while (pending_digests.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
